### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers shared by the RTL; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

### rtl/rgd_pkg.sv
// ----------------------------------------------------------------------------
// rgd_pkg
// Shared types and codes of the run-length grid stream decoder.
// ----------------------------------------------------------------------------
package rgd_pkg;

    localparam int RGD_OUT_DEPTH = 4;

    // Result kinds
    localparam logic [1:0] KIND_ROW    = 2'd0;
    localparam logic [1:0] KIND_RUN    = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
    localparam logic [2:0] ST_ZERO_ROWS = 3'd2;
    localparam logic [2:0] ST_TRUNC_WID = 3'd3;
    localparam logic [2:0] ST_SHORT     = 3'd4;
    localparam logic [2:0] ST_ZERO_RUN  = 3'd5;
    localparam logic [2:0] ST_OVERFLOW  = 3'd6;
    localparam logic [2:0] ST_TRAILING  = 3'd7;

    typedef struct packed {
        logic [1:0]         kind;
        logic [15:0]        row_number;
        logic [31:0]        first_cell;
        logic [15:0]        cell_count;
        logic signed [7:0]  offset_quarter_hours;
        logic [2:0]         status;
    } rgd_result_t;

    // Up to two results per input byte; slot 1 is used only when slot 0 is.
    typedef struct packed {
        logic        v0;
        rgd_result_t r0;
        logic        v1;
        rgd_result_t r1;
    } rgd_push_t;

endpackage

### rtl/rgd_decode.sv
// ----------------------------------------------------------------------------
// rgd_decode
// Per-byte header, width and run token parser with error latch.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgd_decode (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic              final_byte,
    input  logic [31:0]       magic_word,
    output rgd_pkg::rgd_push_t push
);
    import rgd_pkg::*;

    typedef enum logic [2:0] {
        PH_MAGIC  = 3'd0,
        PH_ROWS   = 3'd1,
        PH_WIDTHS = 3'd2,
        PH_RUNS   = 3'd3,
        PH_DONE   = 3'd4
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  bpos_reg, bpos_next;
    logic [23:0] asm_reg, asm_next;
    logic [15:0] row_total_reg, row_total_next;
    logic [15:0] rows_seen_reg, rows_seen_next;
    logic [31:0] cells_total_reg, cells_total_next;
    logic [31:0] cells_filled_reg, cells_filled_next;
    logic        err_reg, err_next;

    logic [2:0]  err_code;
    logic        clear_file;
    logic [15:0] word16;
    logic [32:0] fill_sum;
    logic        rec_valid;
    rgd_result_t rec;
    rgd_result_t stat;
    logic [2:0]  end_status;

    assign word16   = {data_byte, asm_reg[7:0]};
    assign fill_sum = {1'b0, cells_filled_reg} + {17'd0, asm_reg[15:0]};

    always_comb
    begin
        phase_next        = phase_reg;
        bpos_next         = bpos_reg;
        asm_next          = asm_reg;
        row_total_next    = row_total_reg;
        rows_seen_next    = rows_seen_reg;
        cells_total_next  = cells_total_reg;
        cells_filled_next = cells_filled_reg;
        err_next          = err_reg;
        err_code          = ST_OK;
        clear_file        = 1'b0;
        rec_valid         = 1'b0;
        rec               = '0;
        stat              = '0;
        end_status        = ST_OK;
        push              = '0;

        if (accept)
        begin
            if (err_reg)
            begin
                // drop bytes through the final one
                clear_file = final_byte;
            end
            else
            begin
                case (phase_reg)
                    PH_MAGIC:
                    begin
                        if (bpos_reg != 2'd3)
                        begin
                            case (bpos_reg)
                                2'd0: asm_next[7:0]   = data_byte;
                                2'd1: asm_next[15:8]  = data_byte;
                                2'd2: asm_next[23:16] = data_byte;
                                default: asm_next     = asm_reg;
                            endcase
                            bpos_next = bpos_reg + 2'd1;
                        end
                        else
                        begin
                            bpos_next = 2'd0;
                            asm_next  = '0;
                            if ({data_byte, asm_reg} != magic_word)
                                err_code = ST_BAD_MAGIC;
                            else
                                phase_next = PH_ROWS;
                        end
                    end
                    PH_ROWS:
                    begin
                        if (bpos_reg == 2'd0)
                        begin
                            asm_next  = {16'd0, data_byte};
                            bpos_next = 2'd1;
                        end
                        else
                        begin
                            row_total_next = word16;
                            bpos_next      = 2'd0;
                            asm_next       = '0;
                            if (word16 == 16'd0)
                                err_code = ST_ZERO_ROWS;
                            else
                                phase_next = PH_WIDTHS;
                        end
                    end
                    PH_WIDTHS:
                    begin
                        if (bpos_reg == 2'd0)
                        begin
                            asm_next  = {16'd0, data_byte};
                            bpos_next = 2'd1;
                        end
                        else
                        begin
                            bpos_next       = 2'd0;
                            asm_next        = '0;
                            rec_valid       = 1'b1;
                            rec.kind        = KIND_ROW;
                            rec.row_number  = rows_seen_reg;
                            rec.first_cell  = cells_total_reg;
                            rec.cell_count  = word16;
                            cells_total_next = cells_total_reg + {16'd0, word16};
                            rows_seen_next   = rows_seen_reg + 16'd1;
                            if (rows_seen_next == row_total_reg)
                                phase_next = (cells_total_next == 32'd0) ? PH_DONE : PH_RUNS;
                        end
                    end
                    PH_RUNS:
                    begin
                        if (bpos_reg < 2'd2)
                        begin
                            case (bpos_reg)
                                2'd0: asm_next[7:0]  = data_byte;
                                2'd1: asm_next[15:8] = data_byte;
                                default: asm_next    = asm_reg;
                            endcase
                            bpos_next = bpos_reg + 2'd1;
                        end
                        else
                        begin
                            bpos_next = 2'd0;
                            asm_next  = '0;
                            if (asm_reg[15:0] == 16'd0)
                                err_code = ST_ZERO_RUN;
                            else if (fill_sum > {1'b0, cells_total_reg})
                                err_code = ST_OVERFLOW;
                            else
                            begin
                                rec_valid                = 1'b1;
                                rec.kind                 = KIND_RUN;
                                rec.first_cell           = cells_filled_reg;
                                rec.cell_count           = asm_reg[15:0];
                                rec.offset_quarter_hours = $signed(data_byte);
                                cells_filled_next        = fill_sum[31:0];
                                if (fill_sum[31:0] == cells_total_reg)
                                    phase_next = PH_DONE;
                            end
                        end
                    end
                    default:
                    begin
                        err_code = ST_TRAILING;
                    end
                endcase

                stat.kind = KIND_STATUS;
                if (err_code != ST_OK)
                begin
                    stat.status = err_code;
                    push.v0     = 1'b1;
                    push.r0     = stat;
                    if (final_byte)
                        clear_file = 1'b1;
                    else
                        err_next = 1'b1;
                end
                else
                begin
                    case (phase_next)
                        PH_MAGIC, PH_ROWS: end_status = ST_BAD_MAGIC;
                        PH_WIDTHS:         end_status = ST_TRUNC_WID;
                        PH_RUNS:           end_status = ST_SHORT;
                        default:           end_status = ST_OK;
                    endcase
                    stat.status = end_status;
                    if (rec_valid)
                    begin
                        push.v0 = 1'b1;
                        push.r0 = rec;
                        push.v1 = final_byte;
                        push.r1 = stat;
                    end
                    else
                    begin
                        push.v0 = final_byte;
                        push.r0 = stat;
                    end
                    clear_file = final_byte;
                end
            end

            if (clear_file)
            begin
                phase_next        = PH_MAGIC;
                bpos_next         = 2'd0;
                asm_next          = '0;
                row_total_next    = '0;
                rows_seen_next    = '0;
                cells_total_next  = '0;
                cells_filled_next = '0;
                err_next          = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_MAGIC;
            bpos_reg         <= 2'd0;
            asm_reg          <= '0;
            row_total_reg    <= '0;
            rows_seen_reg    <= '0;
            cells_total_reg  <= '0;
            cells_filled_reg <= '0;
            err_reg          <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            bpos_reg         <= bpos_next;
            asm_reg          <= asm_next;
            row_total_reg    <= row_total_next;
            rows_seen_reg    <= rows_seen_next;
            cells_total_reg  <= cells_total_next;
            cells_filled_reg <= cells_filled_next;
            err_reg          <= err_next;
        end
    end

    `ASSERT_NEVER(a_latched_silent, clk, rst_n, err_reg && push.v0)
    `ASSERT_AT(a_second_is_end, clk, rst_n, push.v1 |-> (final_byte && push.v0 && push.r1.kind == KIND_STATUS))
    `ASSERT_NEVER(a_fill_bounded, clk, rst_n, cells_filled_reg > cells_total_reg)

endmodule

### rtl/rgd_outq.sv
// ----------------------------------------------------------------------------
// rgd_outq
// Result queue taking up to two results per cycle, one out per transfer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgd_outq #(
    parameter int Depth = rgd_pkg::RGD_OUT_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rgd_pkg::rgd_push_t   push,
    input  logic                 pop,
    output rgd_pkg::rgd_result_t head,
    output logic                 head_valid,
    output logic                 room
);
    import rgd_pkg::*;

    // Depth is a power of two, at least 2, so pointers wrap by overflow.
    localparam int PtrW = (Depth > 2) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    rgd_result_t mem [Depth];
    logic [PtrW-1:0] wr_reg, wr_next;
    logic [PtrW-1:0] rd_reg, rd_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [CntW-1:0] n_push;
    logic [PtrW-1:0] wr_plus1;

    assign wr_plus1   = wr_reg + PtrW'(1);
    assign n_push     = CntW'(push.v0) + CntW'(push.v1);
    assign head       = mem[rd_reg];
    assign head_valid = (count_reg != '0);
    assign room       = (count_reg <= CntW'(Depth - 2));

    always_comb
    begin
        wr_next    = wr_reg + PtrW'(n_push);
        rd_next    = pop ? rd_reg + PtrW'(1) : rd_reg;
        count_next = count_reg + n_push - CntW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.v0)
            mem[wr_reg] <= push.r0;
        if (push.v1)
            mem[wr_plus1] <= push.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    `ASSERT_NEVER(a_no_overfill, clk, rst_n, count_reg > CntW'(Depth))
    `ASSERT_AT(a_push_seen, clk, rst_n, (count_reg == '0 && push.v0) |=> head_valid)

endmodule

### rtl/rle_grid_stream_decoder.sv
// ----------------------------------------------------------------------------
// rle_grid_stream_decoder
// Streaming decoder for a run-length coded grid file with a header.
// ----------------------------------------------------------------------------
// Feed the file one byte per transfer on s_*, s_tlast on its last byte.
// Results leave on m_*: m_tuser is the kind (row width entry, run record,
// final status), m_tdata carries the record fields.
// Write the expected signature on cfg_* while the block is idle; cfg_ready
// is always high.
// Each byte is parsed in the cycle it is taken; its results are in the
// output queue the next cycle, when m_tvalid rises if the queue was empty.
// One byte per cycle is sustained while s_tready is high: a byte makes at
// most one result; the final byte may add the end status as a second one.
// When the receiver stalls, the output queue fills and s_tready drops once
// fewer than two queue entries are free; nothing is lost.
// Reset empties the queue, clears the signature to zero and restarts the
// parser at the signature. After an error the status is sent once and bytes
// are dropped through the one with s_tlast.
// ----------------------------------------------------------------------------
module rle_grid_stream_decoder #(
    parameter int OutDepth = rgd_pkg::RGD_OUT_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // final_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [15:0] row_number, [47:16] first_cell,
                                   // [63:48] cell_count,
                                   // [71:64] offset_quarter_hours,
                                   // [74:72] status, [79:75] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data   // magic_word
);
    import rgd_pkg::*;

    logic [31:0] magic_reg;
    logic        accept;
    logic        pop;
    logic        room;
    rgd_push_t   push;
    rgd_result_t head;

    assign cfg_ready = 1'b1;
    assign s_tready  = room;
    assign accept    = s_tvalid & room;
    assign pop       = m_tvalid & m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            magic_reg <= '0;
        else if (cfg_valid)
            magic_reg <= cfg_data;
    end

    rgd_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (s_tdata),
        .final_byte (s_tlast),
        .magic_word (magic_reg),
        .push       (push)
    );

    rgd_outq #(
        .Depth (OutDepth)
    ) u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (pop),
        .head       (head),
        .head_valid (m_tvalid),
        .room       (room)
    );

    assign m_tdata = {5'd0, head.status, head.offset_quarter_hours, head.cell_count,
                      head.first_cell, head.row_number};
    assign m_tuser = head.kind;

endmodule
